>>> rtl/core/oapm_pkg.sv
// shared types and constants of the overlap-average patch merge unit
// item structs, queue command, back-end states, register indexes
// no dependencies
package oapm_pkg;

    localparam int SUM_W       = 23;
    localparam int COVER_W     = 11;
    localparam int PAD_W       = 9;
    localparam int CMD_ADDR_W  = 24;
    localparam int CMD_VAL_W   = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0]   SUM_LIMIT   = {SUM_W{1'b1}};
    localparam logic [COVER_W-1:0] COVER_LIMIT = {COVER_W{1'b1}};
    localparam logic [7:0]         PIXEL_MAX   = 8'd255;

    localparam logic [1:0] REQ_ACC   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_SIDE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         origin_x;
        logic [7:0]         origin_y;
        logic [4:0]         offset_x;
        logic [4:0]         offset_y;
        logic [1:0]         chan;
        logic signed [15:0] sample;
        logic [7:0]         read_x;
        logic [7:0]         read_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       status;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ACC,
        CMD_READ,
        CMD_CONST,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [CMD_ADDR_W-1:0] addr;
        logic [1:0]            chan;
        logic [CMD_VAL_W-1:0]  value;
        logic                  status;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       image_width;
        logic [7:0]       image_height;
        logic [5:0]       patch_side;
        logic [2:0]       channel_count;
        logic [PAD_W-1:0] padded_cols;
        logic             busy;
    } cfg_view_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_WAIT,
        ST_RD_PREP,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

>>> rtl/core/oapm_ram.sv
// generic single write port ram with registered read
// no dependencies
module oapm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/oapm_cfg.sv
// configuration registers and padded width derivation
// depends on oapm_pkg
module oapm_cfg #(
    parameter int MAX_DIM = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [oapm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [oapm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output oapm_pkg::cfg_view_t                 view
);
    import oapm_pkg::*;

    logic [7:0]       width_reg;
    logic [7:0]       height_reg;
    logic [5:0]       patch_reg;
    logic [5:0]       step_reg;
    logic [2:0]       chans_reg;
    logic [PAD_W-1:0] padded_reg;
    logic [PAD_W-1:0] cand_reg;
    logic             busy_reg;
    logic             load_reg;
    logic             wr;
    logic             known;
    logic [7:0]       pw;
    logic [5:0]       stride;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign known     = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)
                    || (cfg_index == REG_PATCH_SIDE) || (cfg_index == REG_STEP_SIZE)
                    || (cfg_index == REG_CHANNEL_COUNT);
    assign pw        = (width_reg > {2'b00, patch_reg}) ? width_reg : {2'b00, patch_reg};
    assign stride    = (step_reg == 6'd0) ? 6'd1 : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd224;
            height_reg <= 8'd224;
            patch_reg  <= 6'd16;
            step_reg   <= 6'd8;
            chans_reg  <= 3'd3;
            padded_reg <= '0;
            cand_reg   <= '0;
            busy_reg   <= 1'b1;
            load_reg   <= 1'b1;
        end
        else if (wr && known)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_PATCH_SIDE:    patch_reg  <= cfg_data[5:0];
                REG_STEP_SIZE:     step_reg   <= cfg_data[5:0];
                REG_CHANNEL_COUNT: chans_reg  <= cfg_data[2:0];
                default:           width_reg  <= width_reg;
            endcase
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (load_reg)
            begin
                cand_reg <= PAD_W'(patch_reg);
                load_reg <= 1'b0;
            end
            else if (cand_reg < PAD_W'(pw))
            begin
                // walk patch origins up to the first one covering the width
                cand_reg <= cand_reg + PAD_W'(stride);
            end
            else
            begin
                if (14'(cand_reg) > 14'(MAX_DIM))
                begin
                    padded_reg <= PAD_W'(MAX_DIM);
                end
                else
                begin
                    padded_reg <= cand_reg;
                end
                busy_reg <= 1'b0;
            end
        end
    end

    assign view = '{image_width:   width_reg,
                    image_height:  height_reg,
                    patch_side:    patch_reg,
                    channel_count: chans_reg,
                    padded_cols:   padded_reg,
                    busy:          busy_reg};

endmodule

>>> rtl/core/oapm_front.sv
// front end: accepts items, classifies them and forms the store address
// depends on oapm_pkg
module oapm_front #(
    parameter int MAX_DIM      = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 12
) (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  oapm_pkg::in_item_t   in_item,
    input  oapm_pkg::cfg_view_t  view,
    input  logic                 q_full,
    output logic                 push,
    output oapm_pkg::cmd_t       push_cmd
);
    import oapm_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam logic [CMD_VAL_W-1:0] ONE = CMD_VAL_W'(1) << FRAC_BITS;

    logic [8:0]             col;
    logic [8:0]             row;
    logic [2:0]             eff_chans;
    logic                   chan_ok;
    logic [8:0]             m_row;
    logic [8:0]             m_col;
    logic [DIM_W+PAD_W-1:0] prod;
    logic [ADDR_W-1:0]      pix;
    logic [CMD_VAL_W-1:0]   value;
    logic                   keep;
    cmd_t                   cmd;

    assign col       = 9'(in_item.origin_x) + 9'(in_item.offset_x);
    assign row       = 9'(in_item.origin_y) + 9'(in_item.offset_y);
    assign eff_chans = (view.channel_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS)
                                                             : view.channel_count;
    assign chan_ok   = 3'(in_item.chan) < eff_chans;

    // one multiplier shared by sample and read addressing
    assign m_row = (in_item.req_type == REQ_READ) ? 9'(in_item.read_y) : row;
    assign m_col = (in_item.req_type == REQ_READ) ? 9'(in_item.read_x) : col;
    assign prod  = DIM_W'(m_row) * view.padded_cols;
    assign pix   = ADDR_W'(prod) + ADDR_W'(m_col);

    always_comb
    begin
        if (in_item.sample[15])
        begin
            value = '0;
        end
        else if (CMD_VAL_W'(in_item.sample[14:0]) > ONE)
        begin
            value = ONE;
        end
        else
        begin
            value = CMD_VAL_W'(in_item.sample[14:0]);
        end
    end

    always_comb
    begin
        keep = 1'b0;
        cmd  = '{kind: CMD_CONST, addr: CMD_ADDR_W'(pix), chan: in_item.chan,
                 value: value, status: STATUS_OK};
        unique case (in_item.req_type)
            REQ_ACC:
            begin
                cmd.kind = CMD_ACC;
                keep = (6'(in_item.offset_x) < view.patch_side)
                    && (6'(in_item.offset_y) < view.patch_side)
                    && chan_ok
                    && (col < view.padded_cols)
                    && (14'(row) < 14'(MAX_DIM));
            end
            REQ_READ:
            begin
                keep = 1'b1;
                if ((in_item.read_x >= view.image_width)
                    || (in_item.read_y >= view.image_height))
                begin
                    cmd.status = STATUS_OUTSIDE;
                end
                else if (chan_ok && (9'(in_item.read_x) < view.padded_cols)
                         && (14'(in_item.read_y) < 14'(MAX_DIM)))
                begin
                    cmd.kind = CMD_READ;
                end
            end
            REQ_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = !view.busy && !q_full;
    assign push     = in_valid && in_ready && keep;
    assign push_cmd = cmd;

endmodule

>>> rtl/core/oapm_queue.sv
// short command queue between front and back end
// depends on oapm_pkg
module oapm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  oapm_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output oapm_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);
    import oapm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/oapm_back.sv
// back end: store clearing, read-modify-write accumulate, averaging divider
// depends on oapm_pkg and oapm_ram
module oapm_back #(
    parameter int MAX_DIM      = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oapm_pkg::cmd_t      q_head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output oapm_pkg::out_item_t out_item
);
    import oapm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NW     = 20 + FRAC_BITS;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [NW-1:0]     rem_reg;
    logic [NW-1:0]     dsh_reg;
    logic [7:0]        quot_reg;
    logic [2:0]        step_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic [SUM_W-1:0]   sum_rdata [MAX_CHANNELS];
    logic [SUM_W-1:0]   sum_rd;
    logic [COVER_W-1:0] cover_rd;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [SUM_W-1:0]   sum_wdata;
    logic [COVER_W-1:0] cover_wdata;
    logic               sum_we_any;
    logic               cover_we;
    logic               clearing;
    logic [SUM_W:0]     sum_add;
    logic [NW-1:0]      sum_x;
    logic [NW-1:0]      den;
    logic [NW:0]        diff;
    logic               out_load;
    out_item_t          result;

    assign clearing = state_reg == ST_CLEAR;
    assign raddr    = cmd_reg.addr[ADDR_W-1:0];
    assign waddr    = clearing ? clr_addr_reg : cmd_reg.addr[ADDR_W-1:0];

    genvar g;
    generate
        for (g = 0; g < MAX_CHANNELS; g++)
        begin : g_sum
            oapm_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
                .clk   (clk),
                .we    (clearing || (sum_we_any && (cmd_reg.chan == 2'(g)))),
                .waddr (waddr),
                .wdata (sum_wdata),
                .raddr (raddr),
                .rdata (sum_rdata[g])
            );
        end
    endgenerate

    oapm_ram #(.WIDTH(COVER_W), .DEPTH(DEPTH)) u_cover_ram (
        .clk   (clk),
        .we    (cover_we),
        .waddr (waddr),
        .wdata (cover_wdata),
        .raddr (raddr),
        .rdata (cover_rd)
    );

    always_comb
    begin
        sum_rd = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (cmd_reg.chan == 2'(i))
            begin
                sum_rd = sum_rdata[i];
            end
        end
    end

    assign sum_add = {1'b0, sum_rd} + (SUM_W + 1)'(cmd_reg.value);
    assign sum_x   = NW'(sum_rd);
    assign den     = NW'((cover_rd == '0) ? COVER_W'(1) : cover_rd) << FRAC_BITS;
    assign diff    = {1'b0, rem_reg} - {1'b0, dsh_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind)
                        CMD_ACC:   state_next = ST_ACC_RD;
                        CMD_READ:  state_next = ST_RD_WAIT;
                        CMD_CONST: state_next = ST_OUT;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC_RD:  state_next = ST_ACC_WR;
            ST_ACC_WR:  state_next = ST_IDLE;
            ST_RD_WAIT: state_next = ST_RD_PREP;
            ST_RD_PREP: state_next = (sum_x >= den) ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop       = 1'b0;
        sum_we_any  = 1'b0;
        cover_we    = 1'b0;
        sum_wdata   = '0;
        cover_wdata = '0;
        out_load    = 1'b0;
        result      = '{pixel_value: 8'd0, status: STATUS_OK};
        unique case (state_reg)
            ST_CLEAR:
            begin
                cover_we = 1'b1;
            end
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_ACC_WR:
            begin
                sum_we_any  = 1'b1;
                sum_wdata   = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
                cover_we    = cmd_reg.chan == 2'd0;
                cover_wdata = (cover_rd == COVER_LIMIT) ? cover_rd : cover_rd + 1'b1;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
                if (cmd_reg.kind == CMD_CONST)
                begin
                    result.status = cmd_reg.status;
                end
                else
                begin
                    result.pixel_value = sat_reg ? PIXEL_MAX : quot_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            else
            begin
                clr_addr_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (out_load)
        begin
            out_item_reg <= result;
        end
        if (state_reg == ST_RD_PREP)
        begin
            // numerator 510*sum + den, divisor 2*den aligned to the top quotient bit
            sat_reg  <= sum_x >= den;
            rem_reg  <= (sum_x << 9) - (sum_x << 1) + den;
            dsh_reg  <= den << 8;
            quot_reg <= '0;
            step_reg <= 3'd7;
        end
        else if (state_reg == ST_DIV)
        begin
            if (!diff[NW])
            begin
                rem_reg <= diff[NW-1:0];
            end
            quot_reg <= {quot_reg[6:0], !diff[NW]};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    a_clear_runs_through: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing && clr_addr_reg != ADDR_W'(DEPTH - 1)) |=> clearing)
        else $error("clearing pass left early");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/core/overlap_average_patch_merge_unit.sv
// top level of the overlap-average patch merge unit
// depends on oapm_pkg, oapm_cfg, oapm_front, oapm_queue, oapm_back, oapm_ram
//
// Rebuilds an 8-bit image from overlapping decoded patches by averaging.
// An accumulate item adds its clamped Q3.12 sample to a per-pixel, per-channel
// sum (channel 0 also counts one cover); a read item returns
// round(255*sum/(max(cover,1)*one)) saturated to 255, or status 1 when the
// coordinate lies outside the image; a clear item zeroes both stores.
// The front end classifies each item combinationally and forms the store address
// with a single multiplier; a two-entry queue decouples it from the back end,
// which owns the stores (one sum ram per channel plus a cover ram, each
// MAX_DIM*MAX_DIM deep) and handles one item at a time:
//   accumulate: read, then read-modify-write at the same address
//   read:       an 8-step restoring divider, which is skipped when
//               the average reaches one
//   dropped items: no back-end work; out-of-image items: only the output state
//   clear:      one ram row per cycle through all MAX_DIM*MAX_DIM rows
// After reset the back end runs the same clearing pass before taking queued
// items; up to two items that need back-end work are still queued meanwhile,
// and dropped items keep passing until the queue is full.
// Each configuration write to a known register recomputes the padded width by
// stepping patch origins while input items are held off.
// Results sit in an output register so the next item can proceed meanwhile.
module overlap_average_patch_merge_unit #(
    parameter int MAX_DIM      = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  oapm_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output oapm_pkg::out_item_t              out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [oapm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [oapm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import oapm_pkg::*;

    cfg_view_t view;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;
    logic      q_full;
    logic      q_empty;

    // configuration registers and padded width
    oapm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    // item classification and address forming
    oapm_front #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .view     (view),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    oapm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // stores, accumulate and averaging
    oapm_back #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (head),
        .q_empty   (q_empty),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
